// File: hdl/cartesian_tree_euler_tour_assert.svh
// Assertion macros for the Cartesian tree Euler tour block.
// Used by the datapath; expects clk_i and rst_ni in scope.
`ifndef CARTESIAN_TREE_EULER_TOUR_ASSERT_SVH
`define CARTESIAN_TREE_EULER_TOUR_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CTET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CTET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ctet_pkg.sv
// Shared types for the Cartesian tree Euler tour block.
// Command and status structs between controller and datapath; result codes.
package ctet_pkg;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_ENTRY     = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_FINISHED  = 3'd4
  } status_e;

  typedef struct packed {
    logic    load;     // latch accepted transaction
    logic    append;   // accepted transaction is an append
    logic    drop;     // full: only close if last
    logic    pop;      // build stack pop
    logic    wr_node;  // write new node and push it
    logic    commit;   // link parent, bump counts
    logic    tstart;   // push root
    logic    tstep;    // one Euler step
    logic    tos_load; // reload top of tour stack after a pop
    logic    emit;     // load the output register
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic closed;
    logic full;
    logic cnt_zero;
    logic k_zero;
    logic k_one;
    logic gt;
    logic ph_idle;
    logic ph_fin;
    logic out_free;
    logic step_push;
    logic step_done;
  } sts_t;

endpackage

// File: hdl/cartesian_tree_euler_tour.sv
// Cartesian tree builder with step-wise Euler tour, one transaction at a time.
// Append: the build stack pops at one a cycle in S_ACHK, then S_W1 writes the node,
// S_COMMIT links it and S_EMIT loads the result; then back to S_IDLE for the next.
// Dropped append, not ready, finished: S_ACHK or S_TCHK, then S_EMIT loads the result.
// Tour entry: S_TCHK, then S_TSTEP loads it; after a return S_TPOP reloads the top.
// A held output register adds its stall cycles. Async reset clears control only.
module cartesian_tree_euler_tour #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_opcode_i,
  input  logic signed [31:0] in_value_i,
  input  logic               in_last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic [9:0]         out_node_index_o,
  output logic [9:0]         out_depth_o,
  output logic [10:0]        out_euler_position_o,
  output logic               out_first_visit_o,
  output logic               out_tour_done_o
);

  ctet_pkg::cmd_t cmd;
  ctet_pkg::sts_t sts;

  ctet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ctet_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_value_i           (in_value_i),
    .in_last_element_i    (in_last_element_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_status_o         (out_status_o),
    .out_node_index_o     (out_node_index_o),
    .out_depth_o          (out_depth_o),
    .out_euler_position_o (out_euler_position_o),
    .out_first_visit_o    (out_first_visit_o),
    .out_tour_done_o      (out_tour_done_o)
  );

endmodule

// File: hdl/ctet_ctrl.sv
// Controller for the Cartesian tree Euler tour block.
// Sequences appends and tour steps; drives ctet_pkg::cmd_t to the datapath.
module ctet_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_opcode_i,
  input  ctet_pkg::sts_t  sts_i,
  output ctet_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACHK, S_W1, S_COMMIT, S_TCHK, S_TSTEP, S_TPOP, S_EMIT
  } state_e;

  state_e            state_q, state_d;
  ctet_pkg::status_e code_q, code_d;
  logic              accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load   = 1'b1;
          cmd_o.append = !in_opcode_i;
          state_d      = in_opcode_i ? S_TCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        priority if (sts_i.full) begin
          cmd_o.drop = 1'b1;
          code_d     = ctet_pkg::ST_DROPPED;
          state_d    = S_EMIT;
        end else if (sts_i.k_zero) begin
          state_d = S_W1;
        end else if (sts_i.gt) begin
          cmd_o.pop = 1'b1;
          if (sts_i.k_one) state_d = S_W1;
        end else begin
          state_d = S_W1;
        end
      end
      S_W1: begin
        cmd_o.wr_node = 1'b1;
        state_d       = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        code_d       = ctet_pkg::ST_APPENDED;
        state_d      = S_EMIT;
      end
      S_TCHK: begin
        priority if (!sts_i.closed || sts_i.cnt_zero) begin
          code_d  = ctet_pkg::ST_NOT_READY;
          state_d = S_EMIT;
        end else if (sts_i.ph_fin) begin
          code_d  = ctet_pkg::ST_FINISHED;
          state_d = S_EMIT;
        end else if (sts_i.ph_idle) begin
          cmd_o.tstart = 1'b1;
          state_d      = S_TSTEP;
        end else begin
          state_d = S_TSTEP;
        end
      end
      S_TSTEP: begin
        if (sts_i.out_free) begin
          cmd_o.tstep = 1'b1;
          cmd_o.emit  = 1'b1;
          cmd_o.code  = ctet_pkg::ST_ENTRY;
          state_d     = (sts_i.step_push || sts_i.step_done) ? S_IDLE : S_TPOP;
        end
      end
      S_TPOP: begin
        cmd_o.tos_load = 1'b1;
        state_d        = S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ctet_pkg::ST_APPENDED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// File: hdl/ctet_dpath.sv
// Datapath for the Cartesian tree Euler tour block: build and tour stacks,
// child link memories, counters and the output register. Uses ctet_pkg.
`include "cartesian_tree_euler_tour_assert.svh"
module ctet_dpath #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctet_pkg::cmd_t     cmd_i,
  output ctet_pkg::sts_t     sts_o,
  input  logic signed [31:0] in_value_i,
  input  logic               in_last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic [9:0]         out_node_index_o,
  output logic [9:0]         out_depth_o,
  output logic [10:0]        out_euler_position_o,
  output logic               out_first_visit_o,
  output logic               out_tour_done_o
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = $clog2(2 * MAX_ELEMENTS);
  localparam logic [CW-1:0] NIL = CW'(MAX_ELEMENTS);

  typedef enum logic [1:0] {PH_IDLE, PH_ENTER, PH_RET, PH_FIN} phase_e;

  // memories
  logic [IW-1:0]      bidx_mem [MAX_ELEMENTS];
  logic signed [31:0] bval_mem [MAX_ELEMENTS];
  logic [CW-1:0]      lmem     [MAX_ELEMENTS];
  logic [CW-1:0]      rmem     [MAX_ELEMENTS];
  logic [IW-1:0]      tstk_mem [MAX_ELEMENTS];

  logic [IW-1:0]      bidx_rd_q, tstk_rd_q;
  logic signed [31:0] bval_rd_q;
  logic [CW-1:0]      lrd_q, rrd_q;

  // control state
  logic [CW-1:0] count_q, count_d, btop_q, btop_d, k_q, k_d, ttop_q, ttop_d;
  logic          closed_q, closed_d;
  phase_e        ph_q, ph_d;
  logic [IW-1:0] tos_q, tos_d, level_q, level_d;
  logic [PW-1:0] tcnt_q, tcnt_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic signed [31:0] v_q;
  logic               last_q;
  logic [IW-1:0]      lastpop_q, root_q, prevc_q;
  logic [2:0]         ost_q;
  logic [9:0]         onode_q, odep_q;
  logic [10:0]        opos_q;
  logic               ofirst_q, odone_q;

  logic          clr, out_free, push, done;
  logic [CW-1:0] nxt;
  logic [IW-1:0] bra, tra;

  assign clr      = cmd_i.load && cmd_i.append && closed_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // next Euler move from the current top node
  always_comb begin
    push = 1'b0;
    nxt  = rrd_q;
    unique case (ph_q)
      PH_ENTER: begin
        push = (lrd_q != NIL) || (rrd_q != NIL);
        nxt  = (lrd_q != NIL) ? lrd_q : rrd_q;
      end
      PH_RET: begin
        // returning from the left child: go right if there is one
        push = (lrd_q != NIL) && (lrd_q == CW'(prevc_q)) && (rrd_q != NIL);
      end
      default: push = 1'b0;
    endcase
    done = !push && (ttop_q == CW'(1));
  end

  always_comb begin
    count_d     = count_q;
    btop_d      = btop_q;
    k_d         = k_q;
    closed_d    = closed_q;
    ph_d        = ph_q;
    ttop_d      = ttop_q;
    tos_d       = tos_q;
    level_d     = level_q;
    tcnt_d      = tcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      if (clr) begin
        count_d  = '0;
        btop_d   = '0;
        closed_d = 1'b0;
        ph_d     = PH_IDLE;
        ttop_d   = '0;
        level_d  = '0;
        tcnt_d   = '0;
      end
      k_d = clr ? '0 : btop_q;
    end
    if (cmd_i.drop && last_q) closed_d = 1'b1;
    if (cmd_i.pop) k_d = k_q - CW'(1);
    if (cmd_i.commit) begin
      btop_d  = k_q + CW'(1);
      count_d = count_q + CW'(1);
      if (last_q) closed_d = 1'b1;
    end
    if (cmd_i.tstart) begin
      tos_d   = root_q;
      ttop_d  = CW'(1);
      level_d = '0;
      tcnt_d  = '0;
      ph_d    = PH_ENTER;
    end
    if (cmd_i.tstep) begin
      tcnt_d = tcnt_q + PW'(1);
      if (push) begin
        ttop_d  = ttop_q + CW'(1);
        tos_d   = IW'(nxt);
        level_d = level_q + IW'(1);
        ph_d    = PH_ENTER;
      end else begin
        ttop_d = ttop_q - CW'(1);
        if (level_q != '0) level_d = level_q - IW'(1);
        ph_d = done ? PH_FIN : PH_RET;
      end
    end
    if (cmd_i.tos_load) tos_d = tstk_rd_q;
    if (cmd_i.emit) out_valid_d = 1'b1;
  end

  assign bra = (k_d == '0) ? '0 : IW'(k_d - CW'(1));
  assign tra = (ttop_d == '0) ? '0 : IW'(ttop_d - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      btop_q      <= '0;
      k_q         <= '0;
      closed_q    <= 1'b0;
      ph_q        <= PH_IDLE;
      ttop_q      <= '0;
      tos_q       <= '0;
      level_q     <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      btop_q      <= btop_d;
      k_q         <= k_d;
      closed_q    <= closed_d;
      ph_q        <= ph_d;
      ttop_q      <= ttop_d;
      tos_q       <= tos_d;
      level_q     <= level_d;
      tcnt_q      <= tcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_rd_q <= bidx_mem[bra];
    bval_rd_q <= bval_mem[bra];
    tstk_rd_q <= tstk_mem[tra];
    lrd_q     <= lmem[tos_d];
    rrd_q     <= rmem[tos_d];
    if (cmd_i.load) begin
      v_q    <= in_value_i;
      last_q <= in_last_element_i;
    end
    if (cmd_i.pop) lastpop_q <= bidx_rd_q;
    if (cmd_i.wr_node) begin
      bidx_mem[IW'(k_q)]    <= IW'(count_q);
      bval_mem[IW'(k_q)]    <= v_q;
      lmem[IW'(count_q)]    <= (k_q != btop_q) ? CW'(lastpop_q) : NIL;
      rmem[IW'(count_q)]    <= NIL;
      if (k_q == '0) root_q <= IW'(count_q);
    end else if (cmd_i.commit && (k_q != '0)) begin
      rmem[bidx_rd_q] <= count_q;
    end
    if (cmd_i.tstart) tstk_mem[0] <= root_q;
    if (cmd_i.tstep) begin
      if (push) tstk_mem[IW'(ttop_q)] <= IW'(nxt);
      else      prevc_q <= tos_q;
    end
    if (cmd_i.emit) begin
      ost_q <= cmd_i.code;
      if (cmd_i.code == ctet_pkg::ST_ENTRY) begin
        onode_q  <= 10'(tos_q);
        odep_q   <= 10'(level_q);
        opos_q   <= 11'(tcnt_q);
        ofirst_q <= (ph_q == PH_ENTER);
        odone_q  <= done;
      end else begin
        onode_q  <= '0;
        odep_q   <= '0;
        opos_q   <= '0;
        ofirst_q <= 1'b0;
        odone_q  <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.closed    = closed_q;
    sts_o.full      = (count_q == NIL);
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.k_zero    = (k_q == '0);
    sts_o.k_one     = (k_q == CW'(1));
    sts_o.gt        = (bval_rd_q > v_q);
    sts_o.ph_idle   = (ph_q == PH_IDLE);
    sts_o.ph_fin    = (ph_q == PH_FIN);
    sts_o.out_free  = out_free;
    sts_o.step_push = push;
    sts_o.step_done = done;
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = ost_q;
  assign out_node_index_o     = onode_q;
  assign out_depth_o          = odep_q;
  assign out_euler_position_o = opos_q;
  assign out_first_visit_o    = ofirst_q;
  assign out_tour_done_o      = odone_q;

  `CTET_ASSERT(a_count_bound, count_q <= NIL, "element count beyond capacity")
  `CTET_ASSERT(a_stack_bound, (btop_q <= count_q) && (k_q <= btop_q), "build stack overrun")
  `CTET_ASSERT(a_emit_free, cmd_i.emit |-> out_free, "result overwritten while stalled")
  `CTET_ASSERT_NEXT(a_done_fin, cmd_i.tstep && done, (ph_q == PH_FIN) && (ttop_q == '0),
                    "final entry did not finish the tour")

endmodule

// File: bench/tb_cartesian_tree_euler_tour.sv
// Self-checking bench for cartesian_tree_euler_tour: tree build plus Euler tour.
// Depends on ctet_pkg for status codes; predicts every result in-bench.
`timescale 1ns / 100ps

module tb_cartesian_tree_euler_tour;

  localparam int NMAX = 1024;
  localparam int NULL_LINK = NMAX;
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TOUR = 1'b1;

  typedef struct packed {
    ctet_pkg::status_e status;
    logic [9:0]        node;
    logic [9:0]        depth;
    logic [10:0]       pos;
    logic              first;
    logic              done;
  } tour_res_t;

  typedef struct {
    logic        op;
    logic [31:0] value;
    logic        last;
    logic        has_res;
    tour_res_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_opcode_i = 1'b0;
  logic signed [31:0] in_value_i = '0;
  logic in_last_element_i = 1'b0;
  logic out_stall_i = 1'b1;
  logic in_stall_o, out_valid_o;
  logic [2:0] out_status_o;
  logic [9:0] out_node_index_o, out_depth_o;
  logic [10:0] out_euler_position_o;
  logic out_first_visit_o, out_tour_done_o;

  cartesian_tree_euler_tour dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  int signed nv[NMAX];
  int lc[NMAX], rc[NMAX], bstk[NMAX], tstk[NMAX];
  bit vis[NMAX];
  int btop, ecount, ttop, tlevel, tcount, tphase;
  bit closed;
  tour_res_t expected_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  int n_entries = 0, n_drops = 0, n_arrays = 0;

  function automatic tour_res_t mk(ctet_pkg::status_e s);
    tour_res_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic void clear_walk();
    for (int i = 0; i < NMAX; i++) vis[i] = 1'b0;
    ttop = 0; tlevel = 0; tcount = 0; tphase = 0;
  endfunction

  function automatic tour_res_t predict(logic op, logic [31:0] val, logic last);
    tour_res_t r;
    int k, idx, node, nxt;
    r = '0;
    if (op == OP_APPEND) begin
      if (closed) begin
        ecount = 0; btop = 0; closed = 1'b0; clear_walk();
      end
      if (ecount >= NMAX) begin
        if (last) closed = 1'b1;
        n_drops++;
        return mk(ctet_pkg::ST_DROPPED);
      end
      idx = ecount; k = btop;
      nv[idx] = signed'(val); lc[idx] = NULL_LINK; rc[idx] = NULL_LINK;
      while (k > 0 && nv[bstk[k-1]] > signed'(val)) k--;
      if (k != btop) lc[idx] = bstk[k];
      if (k > 0) rc[bstk[k-1]] = idx;
      bstk[k] = idx; btop = k + 1; ecount = idx + 1;
      if (last) begin
        closed = 1'b1; n_arrays++;
      end
      return mk(ctet_pkg::ST_APPENDED);
    end
    if (!closed || ecount == 0) return mk(ctet_pkg::ST_NOT_READY);
    if (tphase == 3) return mk(ctet_pkg::ST_FINISHED);
    if (tphase == 0) begin
      tstk[0] = bstk[0]; vis[bstk[0]] = 1'b1; ttop = 1; tlevel = 0; tcount = 0; tphase = 1;
    end
    node = tstk[ttop-1];
    r.status = ctet_pkg::ST_ENTRY;
    r.node = 10'(node); r.depth = 10'(tlevel); r.pos = 11'(tcount);
    r.first = (tphase == 1);
    tcount++;
    nxt = NULL_LINK;
    if (lc[node] < NULL_LINK && !vis[lc[node]]) nxt = lc[node];
    else if (rc[node] < NULL_LINK && !vis[rc[node]]) nxt = rc[node];
    if (nxt != NULL_LINK && ttop < NMAX) begin
      tstk[ttop] = nxt; ttop++; vis[nxt] = 1'b1; tlevel++; tphase = 1;
    end else begin
      ttop--;
      if (tlevel > 0) tlevel--;
      tphase = 2;
      if (ttop == 0) begin
        r.done = 1'b1; tphase = 3;
      end
    end
    n_entries++;
    return r;
  endfunction

  // one transaction, held until accepted; valid stays up for a following one
  task automatic send(logic op, logic [31:0] val, logic last, bit chk, tour_res_t want);
    tour_res_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    p = predict(op, val, last);
    if (chk && p != want) begin
      $error("table row disagrees with predictor: want %h got %h", want, p);
      errors++;
    end
    expected_q.insert(expected_q.size(), p);
    in_valid_i <= 1'b1; in_opcode_i <= op; in_value_i <= val; in_last_element_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic tour_all();
    while (closed && tphase != 3)
      send(OP_TOUR, $urandom, 1'($urandom_range(1)), 1'b0, '0);
    send(OP_TOUR, $urandom, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  function automatic logic [31:0] rnd_val(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(7);
      default: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(3))} ^ 32'h0;
    endcase
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    tour_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result, status %0d", out_status_o); errors++;
      end else begin
        w = expected_q.pop_front();
        if (out_status_o !== w.status) begin
          $error("status: exp %0d act %0d", w.status, out_status_o); errors++; end
        if (out_node_index_o !== w.node) begin
          $error("node_index: exp %0d act %0d", w.node, out_node_index_o); errors++; end
        if (out_depth_o !== w.depth) begin
          $error("depth: exp %0d act %0d", w.depth, out_depth_o); errors++; end
        if (out_euler_position_o !== w.pos) begin
          $error("euler_position: exp %0d act %0d", w.pos, out_euler_position_o); errors++; end
        if (out_first_visit_o !== w.first) begin
          $error("first_visit: exp %0d act %0d", w.first, out_first_visit_o); errors++; end
        if (out_tour_done_o !== w.done) begin
          $error("tour_done: exp %0d act %0d", w.done, out_tour_done_o); errors++; end
      end
    end
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    stim_row_t row;
    tour_res_t e;
    int len, mode;
    for (int i = 0; i < NMAX; i++) begin
      lc[i] = NULL_LINK; rc[i] = NULL_LINK;
    end
    btop = 0; ecount = 0; closed = 1'b0; clear_walk();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: tour before close, extremes, equal values, single node, tour over
    e = '0;
    tbl.insert(tbl.size(), '{OP_TOUR,   32'h0,        1'b0, 1'b1, mk(ctet_pkg::ST_NOT_READY)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'h7fffffff, 1'b0, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    tbl.insert(tbl.size(), '{OP_TOUR,   32'hffffffff, 1'b1, 1'b1, mk(ctet_pkg::ST_NOT_READY)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'h80000000, 1'b0, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'h5,        1'b0, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'h5,        1'b0, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'hffffffff, 1'b1, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    for (int i = 0; i < 10; i++) tbl.insert(tbl.size(), '{OP_TOUR, 32'h0, 1'b0, 1'b0, e});
    tbl.insert(tbl.size(), '{OP_TOUR,   32'h0,        1'b0, 1'b1, mk(ctet_pkg::ST_FINISHED)});
    tbl.insert(tbl.size(), '{OP_APPEND, 32'h0,        1'b1, 1'b1, mk(ctet_pkg::ST_APPENDED)});
    tbl.insert(tbl.size(), '{OP_TOUR,   32'h0,        1'b0, 1'b0, e});
    tbl.insert(tbl.size(), '{OP_TOUR,   32'h0,        1'b0, 1'b1, mk(ctet_pkg::ST_FINISHED)});
    foreach (tbl[i]) begin
      row = tbl[i];
      send(row.op, row.value, row.last, row.has_res, row.res);
    end
    drain();

    // full array: fill to capacity, drop one without and one with close, then tour a bit
    for (int i = 0; i < NMAX; i++) send(OP_APPEND, $urandom, 1'b0, 1'b0, '0);
    send(OP_APPEND, $urandom, 1'b0, 1'b1, mk(ctet_pkg::ST_DROPPED));
    send(OP_APPEND, $urandom, 1'b1, 1'b1, mk(ctet_pkg::ST_DROPPED));
    for (int i = 0; i < 20; i++) send(OP_TOUR, 32'h0, 1'b0, 1'b0, '0);
    drain();

    // long receiver hold while the sender keeps offering
    fork
      begin
        hold_recv = 1;
        repeat (300) @(negedge clk_i);
        hold_recv = 0;
      end
      for (int i = 0; i < 40; i++) send(OP_APPEND, rnd_val(1), i == 39, 1'b0, '0);
    join
    tour_all();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
      recv_idle = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
      for (int a = 0; a < 9; a++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(1, 8);
        mode = $urandom_range(2);
        for (int i = 0; i < len; i++)
          send(OP_APPEND, rnd_val(mode), i == len - 1, 1'b0, '0);
        if ($urandom_range(4) == 0)
          send(OP_TOUR, $urandom, 1'($urandom_range(1)), 1'b0, '0);
        else tour_all();
        if ($urandom_range(9) == 0) begin
          send(OP_APPEND, $urandom, 1'b0, 1'b0, '0);
          send(OP_TOUR, $urandom, 1'b0, 1'b0, '0);
        end
      end
      drain();
    end

    $display("Covered %0d arrays, %0d tour entries, %0d dropped appends,",
             n_arrays, n_entries, n_drops);
    $display("with stalls on both sides and a full build store.");
    if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/ctet_pkg.sv
hdl/ctet_ctrl.sv
hdl/ctet_dpath.sv
hdl/cartesian_tree_euler_tour.sv
bench/tb_cartesian_tree_euler_tour.sv
